FILE: sv/rvx_pkg.sv
package rvx_pkg;

	localparam logic [4:0] MD_ADD    = 5'd0;
	localparam logic [4:0] MD_SUB    = 5'd1;
	localparam logic [4:0] MD_SLL    = 5'd2;
	localparam logic [4:0] MD_SLT    = 5'd3;
	localparam logic [4:0] MD_SLTU   = 5'd4;
	localparam logic [4:0] MD_XOR    = 5'd5;
	localparam logic [4:0] MD_SRL    = 5'd6;
	localparam logic [4:0] MD_SRA    = 5'd7;
	localparam logic [4:0] MD_OR     = 5'd8;
	localparam logic [4:0] MD_AND    = 5'd9;
	localparam logic [4:0] MD_MUL    = 5'd10;
	localparam logic [4:0] MD_MULH   = 5'd11;
	localparam logic [4:0] MD_MULHSU = 5'd12;
	localparam logic [4:0] MD_MULHU  = 5'd13;
	localparam logic [4:0] MD_DIV    = 5'd14;
	localparam logic [4:0] MD_DIVU   = 5'd15;
	localparam logic [4:0] MD_REM    = 5'd16;
	localparam logic [4:0] MD_REMU   = 5'd17;
	localparam logic [4:0] MD_LUI    = 5'd18;
	localparam logic [4:0] MD_AUIPC  = 5'd19;
	localparam logic [4:0] MD_JAL    = 5'd20;
	localparam logic [4:0] MD_JALR   = 5'd21;
	localparam logic [4:0] MD_BEQ    = 5'd22;
	localparam logic [4:0] MD_BNE    = 5'd23;
	localparam logic [4:0] MD_BLT    = 5'd24;
	localparam logic [4:0] MD_BGE    = 5'd25;
	localparam logic [4:0] MD_BLTU   = 5'd26;
	localparam logic [4:0] MD_BGEU   = 5'd27;

	localparam logic [31:0] MIN_NEG  = 32'h8000_0000;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	// Number of one-bit divider steps in the back end.
	localparam int DIV_STEPS = 32;

	typedef enum logic [1:0] {
		K_ALU,
		K_MUL,
		K_DIV
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        mul_hi;
		logic        corr_a;
		logic        corr_b;
		logic        want_rem;
		logic        neg_q;
		logic        neg_r;
		logic [31:0] res;
		logic [31:0] opa;
		logic [31:0] opb;
		logic [31:0] npc;
		logic        wr;
		logic        redir;
	} entry_t;

endpackage

FILE: sv/rvx_if.sv
interface rvx_in_if;
	logic               valid;
	logic               ready;
	logic [4:0]         mode;
	logic [31:0]        operand_a;
	logic [31:0]        operand_b;
	logic signed [19:0] half_offset;
	logic [31:0]        pc;

	modport source(output valid, mode, operand_a, operand_b, half_offset, pc, input ready);
	modport sink(input valid, mode, operand_a, operand_b, half_offset, pc, output ready);
endinterface

interface rvx_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result;
	logic        writes_result;
	logic [31:0] next_pc;
	logic        redirect;

	modport source(output valid, result, writes_result, next_pc, redirect, input ready);
	modport sink(input valid, result, writes_result, next_pc, redirect, output ready);
endinterface

FILE: sv/rv32im_integer_execute.sv
// RV32IM execute unit: ALU, branch/jump resolution, multiply and divide.
//
// Channels: in_ch (sink) takes one decoded operation per beat: mode,
// operand_a, operand_b, half_offset and pc. out_ch (source) returns one
// beat per input beat, in order: result, writes_result, next_pc, redirect.
// Both use valid/ready; a beat moves on a rising edge with both high.
//
// Front end decodes the operation and settles ALU, jump and branch results
// in the accept cycle, then pushes into a two-entry queue. The back end is
// a 32-stage pipe: each stage does one restoring divide step, the first
// two stages also form and correct the 32x32 product. Every operation rides
// the same pipe, so order is kept for free.
//
// Throughput: one beat per cycle, sustained while out_ch is ready. Path from
// input accept to output valid: the accept edge writes the queue, then 32
// divide steps and the output register.
// When out_ch stalls the whole pipe holds; the queue absorbs up to two
// more beats before in_ch.ready drops.
// Reset clears the queue and all valid bits; no beat is in flight after.
module rv32im_integer_execute (
	input logic       clk,
	input logic       arst_n,
	rvx_in_if.sink    in_ch,
	rvx_out_if.source out_ch
);
	import rvx_pkg::*;

	entry_t ent, head;
	logic   push, pop, empty, full;

	// Decode and resolve simple operations.
	rvx_front u_front (
		.in_ch (in_ch),
		.full  (full),
		.push  (push),
		.ent   (ent)
	);

	// Decouple front and back so each can stall on its own.
	rvx_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (ent),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	// Multiply, divide and output register.
	rvx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.head_vld (!empty),
		.pop      (pop),
		.out_ch   (out_ch)
	);
endmodule

FILE: sv/rvx_front.sv
module rvx_front (
	rvx_in_if.sink          in_ch,
	input  logic            full,
	output logic            push,
	output rvx_pkg::entry_t ent
);
	import rvx_pkg::*;

	logic [31:0] a, b, target, seq;
	logic [4:0]  sh;
	logic        lt_s, lt_u, eq, div_zero, ovf, take, is_br;

	assign in_ch.ready = !full;
	assign push        = in_ch.valid && !full;

	assign a      = in_ch.operand_a;
	assign b      = in_ch.operand_b;
	assign sh     = b[4:0];
	assign seq    = in_ch.pc + 32'd4;
	assign target = in_ch.pc + {{11{in_ch.half_offset[19]}}, in_ch.half_offset, 1'b0};
	assign lt_s   = $signed(a) < $signed(b);
	assign lt_u   = a < b;
	assign eq     = a == b;
	assign div_zero = b == '0;
	assign ovf    = (a == MIN_NEG) && (b == ALL_ONES);

	always_comb begin
		ent     = '0;
		ent.kind = K_ALU;
		ent.wr  = 1'b1;
		ent.npc = seq;
		take    = 1'b0;
		is_br   = 1'b0;
		unique case (in_ch.mode)
			MD_ADD:  ent.res = a + b;
			MD_SUB:  ent.res = a - b;
			MD_SLL:  ent.res = a << sh;
			MD_SLT:  ent.res = {31'd0, lt_s};
			MD_SLTU: ent.res = {31'd0, lt_u};
			MD_XOR:  ent.res = a ^ b;
			MD_SRL:  ent.res = a >> sh;
			MD_SRA:  ent.res = $unsigned($signed(a) >>> sh);
			MD_OR:   ent.res = a | b;
			MD_AND:  ent.res = a & b;
			MD_MUL, MD_MULH, MD_MULHSU, MD_MULHU: begin
				ent.kind   = K_MUL;
				ent.opa    = a;
				ent.opb    = b;
				ent.mul_hi = in_ch.mode != MD_MUL;
				ent.corr_a = a[31] && (in_ch.mode == MD_MULH || in_ch.mode == MD_MULHSU);
				ent.corr_b = b[31] && (in_ch.mode == MD_MULH);
			end
			MD_DIV, MD_REM: begin
				ent.want_rem = in_ch.mode == MD_REM;
				if (div_zero) begin
					ent.res = ent.want_rem ? a : ALL_ONES;
				end else if (ovf) begin
					ent.res = ent.want_rem ? '0 : MIN_NEG;
				end else begin
					ent.kind  = K_DIV;
					ent.opa   = a[31] ? -a : a;
					ent.opb   = b[31] ? -b : b;
					ent.neg_q = a[31] ^ b[31];
					ent.neg_r = a[31];
				end
			end
			MD_DIVU, MD_REMU: begin
				ent.want_rem = in_ch.mode == MD_REMU;
				if (div_zero) begin
					ent.res = ent.want_rem ? a : ALL_ONES;
				end else begin
					ent.kind = K_DIV;
					ent.opa  = a;
					ent.opb  = b;
				end
			end
			MD_LUI:   ent.res = b;
			MD_AUIPC: ent.res = in_ch.pc + b;
			MD_JAL: begin
				ent.res   = seq;
				ent.npc   = target;
				ent.redir = 1'b1;
			end
			MD_JALR: begin
				ent.res   = seq;
				ent.npc   = (a + b) & ~32'd1;
				ent.redir = 1'b1;
			end
			MD_BEQ:  begin is_br = 1'b1; take = eq;    end
			MD_BNE:  begin is_br = 1'b1; take = !eq;   end
			MD_BLT:  begin is_br = 1'b1; take = lt_s;  end
			MD_BGE:  begin is_br = 1'b1; take = !lt_s; end
			MD_BLTU: begin is_br = 1'b1; take = lt_u;  end
			MD_BGEU: begin is_br = 1'b1; take = !lt_u; end
			default: ent.wr = 1'b0;
		endcase
		if (is_br) begin
			ent.wr = 1'b0;
			if (take) begin
				ent.npc   = target;
				ent.redir = 1'b1;
			end
		end
	end
endmodule

FILE: sv/rvx_queue.sv
module rvx_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rvx_pkg::entry_t wdata,
	input  logic            pop,
	output rvx_pkg::entry_t head,
	output logic            empty,
	output logic            full
);
	import rvx_pkg::*;

	entry_t     mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign empty = cnt_q == 2'd0;
	assign full  = cnt_q == 2'd2;
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop)  rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
endmodule

FILE: sv/rvx_back.sv
module rvx_back (
	input  logic            clk,
	input  logic            arst_n,
	input  rvx_pkg::entry_t head,
	input  logic            head_vld,
	output logic            pop,
	rvx_out_if.source       out_ch
);
	import rvx_pkg::*;

	entry_t      stage_s [DIV_STEPS];
	logic        vld_s   [DIV_STEPS];
	entry_t      nxt     [DIV_STEPS];
	logic        en;
	logic        out_vld_q;
	logic [31:0] res_q, npc_q;
	logic        wr_q, redir_q;
	entry_t      last;
	logic [31:0] fin;
	logic [63:0] prod;

	function automatic entry_t div_step(entry_t e);
		logic [32:0] rq, trial;
		entry_t      o;
		o     = e;
		rq    = {e.res, e.opa[31]};
		trial = rq - {1'b0, e.opb};
		if (!trial[32]) begin
			o.res = trial[31:0];
			o.opa = {e.opa[30:0], 1'b1};
		end else begin
			o.res = rq[31:0];
			o.opa = {e.opa[30:0], 1'b0};
		end
		return o;
	endfunction

	// Advance the whole pipe unless the output beat is held.
	assign en  = !out_vld_q || out_ch.ready;
	assign pop = en && head_vld;

	// Single 32x32 multiplier, fed from the queue head into the first stage.
	assign prod = head.opa * head.opb;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_stage
		entry_t      src;
		if (i == 0) begin : g_first
			assign src = head;
		end else begin : g_rest
			assign src = stage_s[i-1];
		end

		always_comb begin
			nxt[i] = src;
			if (src.kind == K_DIV) begin
				nxt[i] = div_step(src);
			end
			if (i == 0 && src.kind == K_MUL) begin
				nxt[i].res = src.mul_hi ? prod[63:32] : prod[31:0];
			end
			if (i == 1 && src.kind == K_MUL && src.mul_hi) begin
				nxt[i].res = src.res - (src.corr_a ? src.opb : '0) - (src.corr_b ? src.opa : '0);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= (i == 0) ? head_vld : vld_s[(i == 0) ? 0 : i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stage_s[i] <= nxt[i];
			end
		end
	end

	assign last = stage_s[DIV_STEPS-1];

	always_comb begin
		fin = last.res;
		if (last.kind == K_DIV) begin
			if (last.want_rem) begin
				fin = last.neg_r ? -last.res : last.res;
			end else begin
				fin = last.neg_q ? -last.opa : last.opa;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q   <= fin;
			npc_q   <= last.npc;
			wr_q    <= last.wr;
			redir_q <= last.redir;
		end
	end

	assign out_ch.valid         = out_vld_q;
	assign out_ch.result        = res_q;
	assign out_ch.writes_result = wr_q;
	assign out_ch.next_pc       = npc_q;
	assign out_ch.redirect      = redir_q;

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_vld)
		else $error("pop without a queued entry");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ch.ready) |=> $stable(vld_s[DIV_STEPS-1]))
		else $error("pipe moved while output stalled");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s[DIV_STEPS-1]) |=> out_vld_q)
		else $error("finished entry lost");
endmodule

FILE: test/exec_checker.sv
`timescale 1ns / 1ps

module exec_checker
	import rvx_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	rvx_in_if.sink    in_ch,
	rvx_out_if.sink   out_ch,
	output int        fail_count,
	output int        pending
);

	typedef struct {
		logic [31:0] value;
		logic        wr;
		logic [31:0] npc;
		logic        redir;
	} retire_t;

	retire_t retire_q[$];

	function automatic logic [31:0] signed_div(logic [31:0] a, logic [31:0] b, logic want_rem);
		logic [31:0] ma, mb, q, r;
		if (b == 0) return want_rem ? a : ALL_ONES;
		if (a == MIN_NEG && b == ALL_ONES) return want_rem ? 32'd0 : MIN_NEG;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		r = ma % mb;
		if (a[31] ^ b[31]) q = -q;
		if (a[31]) r = -r;
		return want_rem ? r : q;
	endfunction

	function automatic retire_t execute_op(logic [4:0] md, logic [31:0] a, logic [31:0] b,
			logic signed [19:0] ho, logic [31:0] pc);
		retire_t o;
		logic [31:0] target, seq;
		logic signed [63:0] ps;
		logic [63:0] pu;
		logic take;
		target = pc + {{11{ho[19]}}, ho, 1'b0};
		seq = pc + 32'd4;
		o.value = '0; o.wr = 1'b1; o.npc = seq; o.redir = 1'b0;
		take = 1'b0;
		case (md)
			MD_ADD: o.value = a + b;
			MD_SUB: o.value = a - b;
			MD_SLL: o.value = a << b[4:0];
			MD_SLT: o.value = {31'd0, $signed(a) < $signed(b)};
			MD_SLTU: o.value = {31'd0, a < b};
			MD_XOR: o.value = a ^ b;
			MD_SRL: o.value = a >> b[4:0];
			MD_SRA: o.value = $signed(a) >>> b[4:0];
			MD_OR: o.value = a | b;
			MD_AND: o.value = a & b;
			MD_MUL: o.value = a * b;
			MD_MULH: begin
				ps = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
				o.value = ps[63:32];
			end
			MD_MULHSU: begin
				ps = $signed({{32{a[31]}}, a}) * $signed({32'd0, b});
				o.value = ps[63:32];
			end
			MD_MULHU: begin
				pu = {32'd0, a} * {32'd0, b};
				o.value = pu[63:32];
			end
			MD_DIV: o.value = signed_div(a, b, 1'b0);
			MD_DIVU: o.value = (b == 0) ? ALL_ONES : a / b;
			MD_REM: o.value = signed_div(a, b, 1'b1);
			MD_REMU: o.value = (b == 0) ? a : a % b;
			MD_LUI: o.value = b;
			MD_AUIPC: o.value = pc + b;
			MD_JAL: begin
				o.value = seq; o.npc = target; o.redir = 1'b1;
			end
			MD_JALR: begin
				o.value = seq; o.npc = (a + b) & ~32'd1; o.redir = 1'b1;
			end
			MD_BEQ, MD_BNE, MD_BLT, MD_BGE, MD_BLTU, MD_BGEU: begin
				o.wr = 1'b0;
				case (md)
					MD_BEQ: take = a == b;
					MD_BNE: take = a != b;
					MD_BLT: take = $signed(a) < $signed(b);
					MD_BGE: take = $signed(a) >= $signed(b);
					MD_BLTU: take = a < b;
					default: take = a >= b;
				endcase
				if (take) begin
					o.npc = target; o.redir = 1'b1;
				end
			end
			default: o.wr = 1'b0;
		endcase
		return o;
	endfunction

	assign pending = retire_q.size();

	always @(posedge clk or negedge arst_n) begin
		retire_t exp_r;
		int      errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				retire_q.push_back(execute_op(in_ch.mode, in_ch.operand_a, in_ch.operand_b,
					in_ch.half_offset, in_ch.pc));
			if (out_ch.valid && out_ch.ready) begin
				if (retire_q.size() == 0) begin
					$error("result beat with nothing outstanding");
					errs++;
				end else begin
					exp_r = retire_q.pop_front();
					if (out_ch.result !== exp_r.value) begin
						$error("result: expected %h, got %h", exp_r.value, out_ch.result);
						errs++;
					end
					if (out_ch.writes_result !== exp_r.wr) begin
						$error("writes_result: expected %b, got %b", exp_r.wr,
							out_ch.writes_result);
						errs++;
					end
					if (out_ch.next_pc !== exp_r.npc) begin
						$error("next_pc: expected %h, got %h", exp_r.npc, out_ch.next_pc);
						errs++;
					end
					if (out_ch.redirect !== exp_r.redir) begin
						$error("redirect: expected %b, got %b", exp_r.redir, out_ch.redirect);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import rvx_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   beats_sent;
	bit   stimulus_done;

	rvx_in_if  in_ch();
	rvx_out_if out_ch();

	rv32im_integer_execute uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	exec_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mostly short gaps, now and then a long one; zero is common so
	// back-to-back stretches happen too.
	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Drive one beat from the falling edge and hold it until accepted.
	// Valid stays high on return so the next beat can follow with no gap.
	task automatic send_op(logic [4:0] md, logic [31:0] a, logic [31:0] b,
			logic [19:0] ho, logic [31:0] pc);
		int idle;
		idle = gap_len();
		if (idle > 0) begin
			in_ch.valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.mode        <= md;
		in_ch.operand_a   <= a;
		in_ch.operand_b   <= b;
		in_ch.half_offset <= ho;
		in_ch.pc          <= pc;
		do @(posedge clk); while (!in_ch.ready);
		beats_sent++;
		@(negedge clk);
	endtask

	// Pick an operand biased toward the corners that break arithmetic.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return ALL_ONES;
			2: return MIN_NEG;
			3: return MIN_NEG - 1;
			4: return $urandom_range(0, 40);
			5: return -$urandom_range(1, 40);
			default: return $urandom();
		endcase
	endfunction

	// Sink side: drop ready at random, mostly briefly, sometimes for long.
	initial begin
		int hold;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ch.ready <= 1'b1;
			hold = $urandom_range(1, 12);
			repeat (hold) @(negedge clk);
			hold = gap_len();
			if (hold > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end
		end
	end

	initial begin
		logic [31:0] a, b;
		logic [4:0] md;
		in_ch.valid       = 1'b0;
		in_ch.mode        = MD_ADD;
		in_ch.operand_a   = '0;
		in_ch.operand_b   = '0;
		in_ch.half_offset = '0;
		in_ch.pc          = '0;
		beats_sent        = 0;
		stimulus_done     = 0;
		arst_n            = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every operation except the branches, plus the documented corner cases.
		send_op(MD_ADD, ALL_ONES, 32'd1, 20'h7FFFF, ALL_ONES);
		send_op(MD_SUB, 32'd0, 32'd1, 20'h80000, 32'd0);
		send_op(MD_SLL, 32'h1, 32'hFFFF_FFFF, 20'd0, 32'h100);
		send_op(MD_SLT, MIN_NEG, 32'd1, 20'd0, 32'h100);
		send_op(MD_SLTU, MIN_NEG, 32'd1, 20'd0, 32'h100);
		send_op(MD_XOR, 32'hA5A5_A5A5, ALL_ONES, 20'd0, 32'h100);
		send_op(MD_SRL, MIN_NEG, 32'hFFFF_FFE1, 20'd0, 32'h100);
		send_op(MD_SRA, MIN_NEG, 32'd31, 20'd0, 32'h100);
		send_op(MD_SRA, MIN_NEG, 32'd0, 20'd0, 32'h100);
		send_op(MD_OR, 32'h0F0F_0000, 32'h0000_F0F0, 20'd0, 32'h100);
		send_op(MD_AND, ALL_ONES, 32'h1234_5678, 20'd0, 32'h100);
		send_op(MD_MUL, ALL_ONES, ALL_ONES, 20'd0, 32'h100);
		send_op(MD_MULH, MIN_NEG, MIN_NEG, 20'd0, 32'h100);
		send_op(MD_MULHSU, ALL_ONES, ALL_ONES, 20'd0, 32'h100);
		send_op(MD_MULHU, ALL_ONES, ALL_ONES, 20'd0, 32'h100);
		send_op(MD_DIV, 32'd7, 32'd0, 20'd0, 32'h100);
		send_op(MD_DIVU, 32'd7, 32'd0, 20'd0, 32'h100);
		send_op(MD_REM, 32'd7, 32'd0, 20'd0, 32'h100);
		send_op(MD_REMU, 32'd7, 32'd0, 20'd0, 32'h100);
		send_op(MD_DIV, MIN_NEG, ALL_ONES, 20'd0, 32'h100);
		send_op(MD_REM, MIN_NEG, ALL_ONES, 20'd0, 32'h100);
		send_op(MD_LUI, 32'd0, 32'hFFFF_F000, 20'd0, 32'h100);
		send_op(MD_AUIPC, 32'd0, 32'h8000_0000, 20'd0, ALL_ONES);
		send_op(MD_JAL, 32'd0, 32'd0, 20'h80000, 32'h0000_1000);
		send_op(MD_JALR, 32'h1001, 32'hFFFF_FFFF, 20'd0, ALL_ONES - 3);
		in_ch.valid <= 1'b0;

		// Hold off until the pipe has fully drained once.
		wait (pending == 0);

		// Random: all modes including the four unused ones, corner-heavy operands;
		// branches get equal operands often so both outcomes show up.
		repeat (650) begin
			md = 5'($urandom_range(0, 31));
			a = pick_operand();
			b = ($urandom_range(0, 3) == 0) ? a : pick_operand();
			send_op(md, a, b, 20'($urandom()), $urandom());
		end
		in_ch.valid <= 1'b0;

		stimulus_done = 1;
	end

	// Wrap up once the last expected result has come back and the pipe settled.
	initial begin
		wait (stimulus_done);
		wait (pending == 0);
		repeat (50) @(posedge clk);
		$display("Sent %0d operation beats over all 32 modes, corner operands and", beats_sent);
		$display("random stalls on both channels; every result beat checked field by field.");
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
